FILE: design/vector_magnitude_unit_macros.svh
// Assertion macros for the top level of the vector magnitude unit.
`ifndef VECTOR_MAGNITUDE_UNIT_MACROS_SVH
`define VECTOR_MAGNITUDE_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define VMU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds at the given delay after the antecedent.
`define VMU_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

FILE: design/vmag_pkg.sv
// Shared widths, types and latency constants of the vector magnitude unit.
package vmag_pkg;

    localparam int IN_WIDTH  = 32;
    localparam int FRAC_BITS = 16;

    localparam int PORT_W = 32;
    localparam int OUT_W  = 48;

    localparam int SUM_W  = 2 * IN_WIDTH;
    localparam int ROOT_W = IN_WIDTH + FRAC_BITS;
    localparam int REM_W  = ROOT_W + 2;

    // The magnitude, squares and sum stages come first, then the root bit steps.
    localparam int SQ_STAGES = 3;
    localparam int LATENCY   = SQ_STAGES + ROOT_W;

    typedef logic [IN_WIDTH-1:0] t_leg;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [ROOT_W-1:0]   t_root;
    typedef logic [REM_W-1:0]    t_rem;

endpackage

FILE: design/vmag_square.sv
// Leg magnitudes, their squares and the sum of squares, one stage each.
module vmag_square
    import vmag_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [PORT_W-1:0] i_side_a,
    input  logic [PORT_W-1:0] i_side_b,
    output logic              o_vld,
    output t_sum              o_sum
);

    t_leg n_mag_a, n_mag_b;
    t_leg r_mag_a, r_mag_b;
    t_sum r_sq_a, r_sq_b;
    t_sum r_sum;
    logic [SQ_STAGES-1:0] r_vld;

    // Only the low IN_WIDTH bits count; the most negative value maps to 2^(IN_WIDTH-1).
    always_comb begin
        n_mag_a = i_side_a[IN_WIDTH-1] ? (~i_side_a[IN_WIDTH-1:0] + 1'b1)
                                       : i_side_a[IN_WIDTH-1:0];
        n_mag_b = i_side_b[IN_WIDTH-1] ? (~i_side_b[IN_WIDTH-1:0] + 1'b1)
                                       : i_side_b[IN_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_mag_a <= n_mag_a;
        r_mag_b <= n_mag_b;
        r_sq_a  <= SUM_W'(r_mag_a) * SUM_W'(r_mag_a);
        r_sq_b  <= SUM_W'(r_mag_b) * SUM_W'(r_mag_b);
        r_sum   <= r_sq_a + r_sq_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[SQ_STAGES-2:0], i_vld};
        end
    end

    assign o_vld = r_vld[SQ_STAGES-1];
    assign o_sum = r_sum;

endmodule

FILE: design/vmag_sqrt_step.sv
// One restoring square root step that settles one root bit per cycle.
module vmag_sqrt_step
    import vmag_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_rem       i_rem,
    input  t_root      i_root,
    input  logic [1:0] i_pair,
    output logic       o_vld,
    output t_rem       o_rem,
    output t_root      o_root
);

    t_rem  rem_sh, trial;
    logic  take;
    t_rem  n_rem;
    t_root n_root;
    t_rem  r_rem;
    t_root r_root;
    logic  r_vld;

    // Bring down the next two radicand bits and try the trial divisor 4q+1.
    always_comb begin
        rem_sh = {i_rem[REM_W-3:0], i_pair};
        trial  = {i_root, 2'b01};
        take   = (rem_sh >= trial);
        n_rem  = take ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[ROOT_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

FILE: design/vmag_sqrt.sv
// Pipelined square root of the sum of squares scaled by 2^(2*FRAC_BITS).
module vmag_sqrt
    import vmag_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_sum  i_sum,
    output logic  o_vld,
    output t_root o_root
);

    logic  w_vld  [ROOT_W+1];
    t_rem  w_rem  [ROOT_W+1];
    t_root w_root [ROOT_W+1];
    t_sum  r_sum  [IN_WIDTH-1];

    assign w_vld[0]  = i_vld;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [1:0] pair;

        if (k < IN_WIDTH) begin : g_sum_bits
            t_sum sum_k;
            if (k == 0) begin : g_first
                assign sum_k = i_sum;
            end else begin : g_later
                assign sum_k = r_sum[k-1];
            end
            // The sum rides along only as long as later steps still need its bits.
            if (k < IN_WIDTH - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    r_sum[k] <= sum_k;
                end
            end
            assign pair = sum_k[2*(IN_WIDTH-1-k) +: 2];
        end else begin : g_frac_bits
            // Radicand bits below the sum are the zero fraction extension.
            assign pair = 2'b00;
        end

        vmag_sqrt_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[k]),
            .i_rem   (w_rem[k]),
            .i_root  (w_root[k]),
            .i_pair  (pair),
            .o_vld   (w_vld[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_root  (w_root[k+1])
        );
    end

    assign o_vld  = w_vld[ROOT_W];
    assign o_root = w_root[ROOT_W];

endmodule

FILE: design/vector_magnitude_unit.sv
// Top level of the vector magnitude unit: sqrt(a*a + b*b) in Q16 fixed point.
//
// The unit takes one word, a pair of signed legs, in every clock cycle: a word
// is accepted at each rising edge with start high, and busy is never raised.
// Each word gives exactly one result, floor(sqrt(a*a + b*b) * 2^16), shown on
// o_hypotenuse_q16 for exactly one cycle with o_strobe high, in the order the
// words came in. The leg magnitudes, the two 32 by 32 squares and their
// 64-bit sum are registered in turn, and then the square root settles one
// result bit per pipeline stage over 48 stages. The receiver cannot hold
// results off, so it must take every strobed result. The unit keeps no state
// between words; reset only clears the valid bits in flight.
`include "vector_magnitude_unit_macros.svh"

module vector_magnitude_unit
    import vmag_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [PORT_W-1:0] i_side_a,
    input  logic [PORT_W-1:0] i_side_b,
    output logic              o_strobe,
    output logic [OUT_W-1:0]  o_hypotenuse_q16
);

    logic  sq_vld;
    t_sum  sq_sum;
    logic  rt_vld;
    t_root rt_root;
    logic  zero_word;
    logic  zero_result;

    // The pipeline advances every cycle, so a new word is always welcome.
    assign busy = 1'b0;

    // Stages one to three: magnitudes, squares and the exact sum of squares.
    vmag_square u_square (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (start),
        .i_side_a (i_side_a),
        .i_side_b (i_side_b),
        .o_vld    (sq_vld),
        .o_sum    (sq_sum)
    );

    // Remaining stages: one root bit each, most significant first.
    vmag_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sq_vld),
        .i_sum   (sq_sum),
        .o_vld   (rt_vld),
        .o_root  (rt_root)
    );

    assign o_strobe         = rt_vld;
    assign o_hypotenuse_q16 = OUT_W'(rt_root);

    // A word whose legs are both zero, and a result of zero.
    assign zero_word   = start && (i_side_a[IN_WIDTH-1:0] == '0)
                               && (i_side_b[IN_WIDTH-1:0] == '0);
    assign zero_result = (o_hypotenuse_q16 == '0);

    // Every accepted word produces a result at the end of the pipeline.
    `VMU_ASSERT_DLY(a_word_result, i_clk, i_rst_n, start, LATENCY, o_strobe, "accepted word lost")

    // No result appears without a matching accepted word.
    `VMU_ASSERT_IMP(a_no_stray, i_clk, i_rst_n, o_strobe, $past(start, LATENCY), "spurious result")

    // A zero vector has a zero magnitude.
    `VMU_ASSERT_DLY(a_zero_vector, i_clk, i_rst_n, zero_word, LATENCY, zero_result, "nonzero root")

endmodule

FILE: bench/vmag_result_checker.sv
// Result checker for the vector magnitude unit: predicts each word's magnitude and compares.
module vmag_result_checker
    import vmag_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [PORT_W-1:0] i_side_a,
    input  logic [PORT_W-1:0] i_side_b,
    input  logic              i_strobe,
    input  logic [OUT_W-1:0]  i_hypotenuse_q16,
    output int                o_failures,
    output int                o_pending
);

    typedef struct {
        logic [PORT_W-1:0] side_a;
        logic [PORT_W-1:0] side_b;
        logic [OUT_W-1:0]  hypot;
    } t_expected_hypot;

    t_expected_hypot expected_hypots[$];
    t_expected_hypot head;
    int              fail_count = 0;

    initial begin
        o_failures = 0;
        o_pending  = 0;
    end

    // Absolute value of a leg taken from the low IN_WIDTH bits of its port.
    function automatic t_leg leg_abs(input logic [PORT_W-1:0] raw);
        t_leg leg;
        leg = raw[IN_WIDTH-1:0];
        return leg[IN_WIDTH-1] ? t_leg'(~leg + 1'b1) : leg;
    endfunction

    // floor(sqrt((a^2 + b^2) * 2^(2*FRAC_BITS))), settled one root bit at a time.
    function automatic logic [OUT_W-1:0] hypot_q16(input logic [PORT_W-1:0] a_raw,
                                                    input logic [PORT_W-1:0] b_raw);
        logic [127:0] mag_a;
        logic [127:0] mag_b;
        logic [127:0] radicand;
        logic [127:0] trial_sq;
        t_root        root;
        t_root        trial;
        mag_a    = 128'(leg_abs(a_raw));
        mag_b    = 128'(leg_abs(b_raw));
        radicand = (mag_a * mag_a + mag_b * mag_b) << (2 * FRAC_BITS);
        root     = '0;
        for (int k = ROOT_W - 1; k >= 0; k--) begin
            trial    = root | (t_root'(1) << k);
            trial_sq = 128'(trial) * 128'(trial);
            if (trial_sq <= radicand) begin
                root = trial;
            end
        end
        return OUT_W'(root);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            // Results are compared before the new word is queued, so a result can
            // never be matched against a word taken at the same edge.
            if (i_strobe === 1'b1) begin
                if (expected_hypots.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("checker: unexpected result %0d", i_hypotenuse_q16);
                    end
                    fail_count++;
                end else begin
                    head = expected_hypots.pop_front();
                    if (i_hypotenuse_q16 !== head.hypot) begin
                        if (fail_count < 10) begin
                            $display("checker: a=%h b=%h expected %0d got %0d",
                                     head.side_a, head.side_b, head.hypot,
                                     i_hypotenuse_q16);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                expected_hypots.push_back('{i_side_a, i_side_b,
                                            hypot_q16(i_side_a, i_side_b)});
            end
        end
        o_failures <= fail_count;
        o_pending  <= expected_hypots.size();
    end

endmodule

FILE: bench/vector_magnitude_unit_tb.sv
// Testbench top for the vector magnitude unit: drives words and gives the verdict.
module vector_magnitude_unit_tb;
    import vmag_pkg::*;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              start    = 1'b0;
    logic              busy;
    logic [PORT_W-1:0] i_side_a = '0;
    logic [PORT_W-1:0] i_side_b = '0;
    logic              o_strobe;
    logic [OUT_W-1:0]  o_hypotenuse_q16;
    int                failures;
    int                pending;

    // Free-running clock with a period of 8 time units.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    vector_magnitude_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_side_a         (i_side_a),
        .i_side_b         (i_side_b),
        .o_strobe         (o_strobe),
        .o_hypotenuse_q16 (o_hypotenuse_q16)
    );

    // The checker sits beside the unit, watches both channels and owns all
    // prediction; the top only makes words and reads back the failure count.
    vmag_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_side_a         (i_side_a),
        .i_side_b         (i_side_b),
        .i_strobe         (o_strobe),
        .i_hypotenuse_q16 (o_hypotenuse_q16),
        .o_failures       (failures),
        .o_pending        (pending)
    );

    // Offers one word and returns once the unit has taken it. Before the word,
    // each cycle is left idle with the given chance in percent, so that gaps
    // fall at random points of the pipeline. All driving happens with
    // nonblocking assignments right after a rising edge, and start gets only
    // one assignment per time step.
    task automatic send_word(input logic [PORT_W-1:0] a, input logic [PORT_W-1:0] b,
                             input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_side_a <= a;
        i_side_b <= b;
        // Busy read just after the edge still holds its value from before the
        // edge, which is the value that decided acceptance.
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drops start and waits until the checker holds no open expectation. It
    // waits for a rising edge first so that the last accepted word shows in the count.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Random pair of legs. Four in ten pairs are fully random; the rest are aimed at
    // small values, a zero leg, values near both extremes, exact Pythagorean
    // triples and values of random bit length.
    task automatic make_pair(output logic [PORT_W-1:0] a, output logic [PORT_W-1:0] b);
        int                kind;
        logic [PORT_W-1:0] k;
        kind = $urandom_range(9);
        case (kind)
            4: begin
                a = $urandom_range(255);
                b = $urandom_range(255);
            end
            5: begin
                a = $urandom;
                b = '0;
                if ($urandom_range(1)) begin
                    b = a;
                    a = '0;
                end
            end
            6: begin
                a = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(7)
                                      : 32'h7FFF_FFFF - $urandom_range(7);
                b = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(7)
                                      : 32'h7FFF_FFFF - $urandom_range(7);
            end
            7: begin
                k = $urandom_range(32'h1FFF_FFFF);
                a = 3 * k;
                b = 4 * k;
            end
            8, 9: begin
                a = $urandom >> $urandom_range(31);
                b = $urandom >> $urandom_range(31);
            end
            default: begin
                a = $urandom;
                b = $urandom;
            end
        endcase
        // Random signs for the shaped kinds but the extremes; fully random legs carry their own.
        if (kind >= 4 && kind != 6) begin
            if ($urandom_range(1)) a = ~a + 1'b1;
            if ($urandom_range(1)) b = ~b + 1'b1;
        end
    endtask

    initial begin
        logic [PORT_W-1:0] ra;
        logic [PORT_W-1:0] rb;
        int                idle_pct;

        // Synchronous reset held from the start, released once and never again.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: the zero vector, both extremes of each leg, the most
        // negative value against itself and against the most positive, unit
        // legs, an exact triple and alternating bit patterns.
        send_word(32'h0000_0000, 32'h0000_0000, 34);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 34);
        send_word(32'h8000_0000, 32'h8000_0000, 34);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 34);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 34);
        send_word(32'h8000_0000, 32'h0000_0000, 34);
        send_word(32'h0000_0000, 32'h8000_0000, 34);
        send_word(32'h7FFF_FFFF, 32'h0000_0000, 34);
        send_word(32'h0000_0001, 32'h0000_0000, 34);
        send_word(32'h0000_0000, 32'hFFFF_FFFF, 34);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 34);
        send_word(32'h0000_0001, 32'h0000_0001, 34);
        send_word(32'h0000_0003, 32'hFFFF_FFFC, 34);
        send_word(32'h0000_0002, 32'h0000_0000, 34);
        send_word(32'hAAAA_AAAA, 32'h5555_5555, 34);
        send_word(32'h5555_5555, 32'hAAAA_AAAA, 34);
        send_word(32'h8000_0001, 32'h0000_0001, 34);
        send_word(32'h0001_0000, 32'hFFFF_0000, 34);
        drain_results();

        // Random words in three phases: a light sender gap rate, a heavy one,
        // then back to back. The unit drains completely between phases.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 34 : (phase == 1) ? 60 : 0;
            for (int n = 0; n < 567; n++) begin
                make_pair(ra, rb);
                send_word(ra, rb, idle_pct);
            end
            drain_results();
        end

        // Let any stray strobe show up after the last expected result.
        repeat (LATENCY + 8) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
